>>> hdl/btpc_pkg.sv
// ---------------------------------------------------------------------------
// Barometer compensation package
// Shared types, register codes, constants and pipeline depths for the
// temperature and pressure compensation pipeline.
// ---------------------------------------------------------------------------
package btpc_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_CAL_TEMP    = 2'd0,
    REG_CAL_PRESS_A = 2'd1,
    REG_CAL_PRESS_B = 2'd2,
    REG_CAL_PRESS_C = 2'd3
  } cfg_reg_e;

  // Compensation constants
  localparam logic [31:0] FINE_OFFSET  = 32'd64000;
  localparam logic [31:0] DIV_BASE     = 32'd32768;
  localparam logic [31:0] PRESS_SCALE  = 32'd1048576;
  localparam logic [31:0] PRESS_MULT   = 32'd3125;
  localparam logic [31:0] TEMP_ROUND   = 32'd128;
  localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
  localparam logic signed [31:0] TEMP_MIN = -32'sd32768;
  localparam logic signed [33:0] PRESS_MAX = 34'sd262143;

  // Pipeline depths
  localparam int TEMP_STAGES = 3;
  localparam int COEF_STAGES = 6;
  localparam int DIV_STAGES  = 32;
  localparam int FIN_STAGES  = 3;
  localparam int LATENCY     = TEMP_STAGES + COEF_STAGES + DIV_STAGES + FIN_STAGES;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] temperature_centideg;
    logic [17:0]        pressure_pa;
    logic               pressure_valid;
  } result_t;

  // Calibration words, already extended to the 32-bit datapath.
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [31:0] p7;
    logic [31:0] p8;
    logic [31:0] p9;
  } cal_t;

  typedef struct packed {
    logic [31:0] a;
    logic [15:0] temperature;
    logic [19:0] raw_pressure;
  } temp_out_t;

  typedef struct packed {
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic        doubled;
    logic        pvalid;
    logic [15:0] temperature;
  } div_in_t;

  typedef struct packed {
    logic [31:0] quotient;
    logic        doubled;
    logic        pvalid;
    logic [15:0] temperature;
  } div_out_t;

endpackage

>>> hdl/btpc_temp.sv
// ---------------------------------------------------------------------------
// Temperature stages
// Three register stages that form the fine temperature, the saturated
// temperature in 0.01 degC and the first pressure term.
// ---------------------------------------------------------------------------
module btpc_temp
  import btpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  sample_t   sample,
  input  cal_t      cal,
  output logic      out_valid,
  output temp_out_t out_data
);

  logic        s1_valid;
  logic [31:0] s1_m1;
  logic [31:0] s1_m2;
  logic [19:0] s1_rawp;
  logic        s2_valid;
  logic [31:0] s2_v1;
  logic [31:0] s2_m3;
  logic [19:0] s2_rawp;

  logic [31:0] x1;
  logic [31:0] dt;
  logic [31:0] m2_sh;
  logic [31:0] v2;
  logic [31:0] tf;
  logic [31:0] t5;
  logic [31:0] tt;
  logic [15:0] t_sat;
  logic [31:0] a0;

  always_comb begin
    x1    = {15'd0, sample.raw_temperature[19:3]} - {cal.t1[30:0], 1'b0};
    dt    = {16'd0, sample.raw_temperature[19:4]} - cal.t1;
    m2_sh = 32'($signed(s1_m2) >>> 12);
    v2    = 32'($signed(s2_m3) >>> 14);
    tf    = s2_v1 + v2;
    t5    = {tf[29:0], 2'b00} + tf + TEMP_ROUND;
    tt    = 32'($signed(t5) >>> 8);
    if ($signed(tt) > TEMP_MAX) begin
      t_sat = TEMP_MAX[15:0];
    end else if ($signed(tt) < TEMP_MIN) begin
      t_sat = TEMP_MIN[15:0];
    end else begin
      t_sat = tt[15:0];
    end
    a0 = 32'($signed(tf) >>> 1) - FINE_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_m1   <= x1 * cal.t2;
    s1_m2   <= dt * dt;
    s1_rawp <= sample.raw_pressure;
    s2_v1   <= 32'($signed(s1_m1) >>> 11);
    s2_m3   <= m2_sh * cal.t3;
    s2_rawp <= s1_rawp;
    out_data.a            <= a0;
    out_data.temperature  <= t_sat;
    out_data.raw_pressure <= s2_rawp;
  end

endmodule

>>> hdl/btpc_coef.sv
// ---------------------------------------------------------------------------
// Pressure coefficient stages
// Six register stages that build the pressure divisor and the scaled
// dividend, and choose how the quotient is to be doubled.
// ---------------------------------------------------------------------------
module btpc_coef
  import btpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  temp_out_t in_data,
  input  cal_t      cal,
  output logic      out_valid,
  output div_in_t   out_data
);

  logic [COEF_STAGES-2:0] vld;

  // Stage 1
  logic [31:0] c1_qq;
  logic [31:0] c1_ma5;
  logic [31:0] c1_mp2;
  logic [15:0] c1_temp;
  logic [19:0] c1_rawp;
  // Stage 2
  logic [31:0] c2_b;
  logic [31:0] c2_mp3;
  logic [31:0] c2_mp2;
  logic [15:0] c2_temp;
  logic [19:0] c2_rawp;
  // Stage 3
  logic [31:0] c3_b;
  logic [31:0] c3_s;
  logic [15:0] c3_temp;
  logic [19:0] c3_rawp;
  // Stage 4
  logic [31:0] c4_div;
  logic [31:0] c4_x;
  logic [15:0] c4_temp;
  // Stage 5
  logic [31:0] c5_p;
  logic [31:0] c5_div;
  logic [15:0] c5_temp;

  logic [31:0] q;
  logic [31:0] qq11;
  logic [31:0] qq13;
  logic [31:0] b_mul;
  logic [31:0] a_sum;
  logic [31:0] a2;
  logic [31:0] sp1;
  logic [31:0] x0;

  always_comb begin
    q     = 32'($signed(in_data.a) >>> 2);
    qq11  = 32'($signed(c1_qq) >>> 11);
    qq13  = 32'($signed(c1_qq) >>> 13);
    b_mul = qq11 * cal.p6;
    a_sum = 32'($signed(c2_mp3) >>> 3) + 32'($signed(c2_mp2) >>> 1);
    a2    = 32'($signed(a_sum) >>> 18);
    sp1   = c3_s * cal.p1;
    x0    = (PRESS_SCALE - {12'd0, c3_rawp}) - 32'($signed(c3_b) >>> 12);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[COEF_STAGES-3:0], in_valid};
      out_valid <= vld[COEF_STAGES-2];
    end
  end

  always_ff @(posedge clk) begin
    c1_qq   <= q * q;
    c1_ma5  <= in_data.a * cal.p5;
    c1_mp2  <= cal.p2 * in_data.a;
    c1_temp <= in_data.temperature;
    c1_rawp <= in_data.raw_pressure;

    c2_b    <= b_mul + {c1_ma5[30:0], 1'b0};
    c2_mp3  <= cal.p3 * qq13;
    c2_mp2  <= c1_mp2;
    c2_temp <= c1_temp;
    c2_rawp <= c1_rawp;

    c3_b    <= 32'($signed(c2_b) >>> 2) + {cal.p4[15:0], 16'd0};
    c3_s    <= DIV_BASE + a2;
    c3_temp <= c2_temp;
    c3_rawp <= c2_rawp;

    c4_div  <= 32'($signed(sp1) >>> 15);
    c4_x    <= x0;
    c4_temp <= c3_temp;

    c5_p    <= c4_x * PRESS_MULT;
    c5_div  <= c4_div;
    c5_temp <= c4_temp;

    // Below 2^31 the value is doubled before dividing, otherwise the
    // quotient is doubled afterwards.
    out_data.doubled     <= c5_p[31];
    out_data.dividend    <= c5_p[31] ? c5_p : {c5_p[30:0], 1'b0};
    out_data.divisor     <= c5_div;
    out_data.pvalid      <= (c5_div != '0);
    out_data.temperature <= c5_temp;
  end

endmodule

>>> hdl/btpc_div.sv
// ---------------------------------------------------------------------------
// Pipelined divider
// Unsigned 32-bit by 32-bit restoring division, one quotient bit per
// register stage, with side data carried alongside.
// ---------------------------------------------------------------------------
module btpc_div
  import btpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  div_in_t  in_data,
  output logic     out_valid,
  output div_out_t out_data
);

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] divisor;
    logic        doubled;
    logic        pvalid;
    logic [15:0] temperature;
  } div_stage_t;

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t  r;
    logic [32:0] trial;
    logic [32:0] diff;
    r     = s;
    trial = {s.rem, s.num[31]};
    diff  = trial - {1'b0, s.divisor};
    if (!diff[32]) begin
      r.rem = diff[31:0];
      r.num = {s.num[30:0], 1'b1};
    end else begin
      r.rem = trial[31:0];
      r.num = {s.num[30:0], 1'b0};
    end
    return r;
  endfunction

  div_stage_t          head;
  div_stage_t          stg [1:DIV_STAGES];
  logic [DIV_STAGES:1] vld;

  always_comb begin
    head.rem         = '0;
    head.num         = in_data.dividend;
    head.divisor     = in_data.divisor;
    head.doubled     = in_data.doubled;
    head.pvalid      = in_data.pvalid;
    head.temperature = in_data.temperature;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STAGES-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    stg[1] <= div_step(head);
    for (int i = 1; i < DIV_STAGES; i++) begin
      stg[i+1] <= div_step(stg[i]);
    end
  end

  assign out_valid            = vld[DIV_STAGES];
  assign out_data.quotient    = stg[DIV_STAGES].num;
  assign out_data.doubled     = stg[DIV_STAGES].doubled;
  assign out_data.pvalid      = stg[DIV_STAGES].pvalid;
  assign out_data.temperature = stg[DIV_STAGES].temperature;

endmodule

>>> hdl/btpc_final.sv
// ---------------------------------------------------------------------------
// Pressure correction stages
// Three register stages that apply the second-order correction to the
// quotient, saturate the pressure and register the result.
// ---------------------------------------------------------------------------
module btpc_final
  import btpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  div_out_t in_data,
  input  cal_t     cal,
  output logic     out_valid,
  output result_t  out_data
);

  logic        f1_valid;
  logic [31:0] f1_p;
  logic [31:0] f1_sq;
  logic [31:0] f1_m8;
  logic        f1_pvalid;
  logic [15:0] f1_temp;
  logic        f2_valid;
  logic [31:0] f2_p;
  logic [31:0] f2_corr;
  logic        f2_pvalid;
  logic [15:0] f2_temp;

  logic [31:0]        p;
  logic [31:0]        p3;
  logic [31:0]        sq_full;
  logic [31:0]        c1;
  logic [31:0]        corr_sum;
  logic signed [33:0] fin;
  logic [17:0]        press;

  always_comb begin
    p        = in_data.doubled ? {in_data.quotient[30:0], 1'b0} : in_data.quotient;
    p3       = {3'd0, p[31:3]};
    sq_full  = p3 * p3;
    c1       = 32'($signed(cal.p9 * f1_sq) >>> 12);
    corr_sum = c1 + 32'($signed(f1_m8) >>> 13) + cal.p7;
    fin      = $signed({2'b00, f2_p}) + $signed({{2{f2_corr[31]}}, f2_corr});
    if (fin < 0) begin
      press = '0;
    end else if (fin > PRESS_MAX) begin
      press = PRESS_MAX[17:0];
    end else begin
      press = fin[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      f2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      f1_valid  <= in_valid;
      f2_valid  <= f1_valid;
      out_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_p      <= p;
    f1_sq     <= {13'd0, sq_full[31:13]};
    f1_m8     <= {2'd0, p[31:2]} * cal.p8;
    f1_pvalid <= in_data.pvalid;
    f1_temp   <= in_data.temperature;
    f2_p      <= f1_p;
    f2_corr   <= 32'($signed(corr_sum) >>> 4);
    f2_pvalid <= f1_pvalid;
    f2_temp   <= f1_temp;
    out_data.temperature_centideg <= $signed(f2_temp);
    out_data.pressure_pa          <= f2_pvalid ? press : '0;
    out_data.pressure_valid       <= f2_pvalid;
  end

endmodule

>>> hdl/baro_temp_pressure_compensation.sv
// ---------------------------------------------------------------------------
// Barometer temperature and pressure compensation
// Fully pipelined 32-bit integer compensation of one raw temperature and
// one raw pressure sample into 0.01 degC and pascals.
// ---------------------------------------------------------------------------
// A sample pair may be transferred in every clock cycle: it is taken when
// start is high and busy is low, and busy is only high during reset. Each
// sample produces exactly one result, which appears on the result port for
// one cycle with done high. The receiver cannot stall, so results must be
// captured as they appear. Most of the pipeline is the 32-stage divider,
// which produces one quotient bit per stage; the remaining twelve stages
// hold the multiplications of the temperature and pressure formulae, at
// most one multiplier deep each. Calibration registers should only be
// written while no sample is in flight.
// ---------------------------------------------------------------------------
module baro_temp_pressure_compensation
  import btpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Sample channel
  input  logic                  start,
  output logic                  busy,
  input  sample_t               sample,
  // Result channel
  output logic                  done,
  output result_t               result,
  // Calibration write port
  input  logic                  cfg_we,
  input  cfg_reg_e              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Calibration registers, laid out as the sensor's trimming words.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_c;

  cal_t      cal;
  logic      accept;
  logic      temp_valid;
  temp_out_t temp_data;
  logic      coef_valid;
  div_in_t   coef_data;
  logic      div_valid;
  div_out_t  div_data;

  // The pipeline never stalls, so the only time a transfer is refused is
  // while the valid bits are being cleared.
  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_press_c <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_TEMP:    cal_temp    <= cfg_wdata[47:0];
        REG_CAL_PRESS_A: cal_press_a <= cfg_wdata;
        REG_CAL_PRESS_B: cal_press_b <= cfg_wdata;
        REG_CAL_PRESS_C: cal_press_c <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Unpack the coefficients. T1 and P1 are unsigned; every other word is
  // sign-extended to the 32-bit datapath width.
  always_comb begin
    cal.t1 = {16'd0, cal_temp[15:0]};
    cal.t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    cal.t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    cal.p1 = {16'd0, cal_press_a[15:0]};
    cal.p2 = {{16{cal_press_a[31]}}, cal_press_a[31:16]};
    cal.p3 = {{16{cal_press_a[47]}}, cal_press_a[47:32]};
    cal.p4 = {{16{cal_press_a[63]}}, cal_press_a[63:48]};
    cal.p5 = {{16{cal_press_b[15]}}, cal_press_b[15:0]};
    cal.p6 = {{16{cal_press_b[31]}}, cal_press_b[31:16]};
    cal.p7 = {{16{cal_press_b[47]}}, cal_press_b[47:32]};
    cal.p8 = {{16{cal_press_b[63]}}, cal_press_b[63:48]};
    cal.p9 = {{16{cal_press_c[15]}}, cal_press_c};
  end

  // Fine temperature, saturated temperature and the first pressure term.
  btpc_temp u_temp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .sample    (sample),
    .cal       (cal),
    .out_valid (temp_valid),
    .out_data  (temp_data)
  );

  // Pressure divisor and dividend.
  btpc_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (temp_valid),
    .in_data   (temp_data),
    .cal       (cal),
    .out_valid (coef_valid),
    .out_data  (coef_data)
  );

  // One quotient bit per stage.
  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coef_valid),
    .in_data   (coef_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  // Second-order correction, saturation and the output register.
  btpc_final u_final (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .cal       (cal),
    .out_valid (done),
    .out_data  (result)
  );

  // Every transfer in gives exactly one result, a fixed number of cycles on.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing after accepted sample");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching sample");

  // A zero divisor must never leak a pressure value.
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.pressure_valid |-> result.pressure_pa == '0)
    else $error("pressure reported with zero divisor");

endmodule
